// ===== rtl/bgr_pkg.sv =====
// Shared types and constants for the bitmap text glyph renderer.
// No dependencies; imported by every rtl module of the block.
package bgr_pkg;

  localparam int CELL = 8;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam int DEF_SCREEN_PIXELS_WIDE = 640;
  localparam int DEF_SCREEN_PIXELS_HIGH = 480;
  localparam int DEF_GLYPH_COUNT        = 256;
  localparam int DEF_FIFO_DEPTH         = 4;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int ADDR_W     = 16;

  typedef enum logic [1:0] {
    MODE_DRAW = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_HOME = 2'd2
  } mode_t;

  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_kind_t;

  // one queued command: a glyph draw at a byte address, or one font row write
  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         code;
    logic [2:0]         row;
    logic [7:0]         bits;
    logic [ADDR_W-1:0]  base;
    logic               blank;
  } bgr_cmd_t;

  typedef struct packed {
    logic clearing;
  } bgr_status_t;

  typedef enum logic {
    BK_CLEAR = 1'b0,
    BK_RUN   = 1'b1
  } back_state_t;

endpackage

// ===== rtl/bitmap_text_glyph_renderer_core.sv =====
// Bitmap text glyph renderer, 8x8 monochrome font.
// An accepted draw beat passes the command queue, the font read stage and the output register
// before its first framebuffer write beat. A draw makes one font memory read per output row on
// the single read port, only while the output side has room; loads write the font memory in the
// back end; home and newline only move the cursor in the front. Reset: cursor to top left, then
// a sweep zeroes all GLYPH_COUNT*8 font entries, with s_axis_tready low throughout.
module bitmap_text_glyph_renderer_core import bgr_pkg::*; #(
  parameter int SCREEN_PIXELS_WIDE = DEF_SCREEN_PIXELS_WIDE,
  parameter int SCREEN_PIXELS_HIGH = DEF_SCREEN_PIXELS_HIGH,
  parameter int GLYPH_COUNT        = DEF_GLYPH_COUNT,
  parameter int FIFO_DEPTH         = DEF_FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // char_code[7:0], glyph_row[10:8], glyph_bits[18:11]
  input  logic [1:0]            s_axis_tuser,  // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // fb_address[15:0], fb_data[23:16]
  output logic                  m_axis_tlast   // last_row
);

  logic        push;
  bgr_cmd_t    push_cmd;
  logic        fifo_full;
  bgr_cmd_t    head;
  logic        head_valid;
  logic        pop;
  bgr_status_t status;

  bgr_front #(
    .SCREEN_PIXELS_WIDE (SCREEN_PIXELS_WIDE),
    .SCREEN_PIXELS_HIGH (SCREEN_PIXELS_HIGH),
    .GLYPH_COUNT        (GLYPH_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fifo_full     (fifo_full),
    .status        (status),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  bgr_cmd_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (fifo_full)
  );

  bgr_back #(
    .SCREEN_PIXELS_WIDE (SCREEN_PIXELS_WIDE),
    .GLYPH_COUNT        (GLYPH_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .status        (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/bgr_front.sv =====
// Front end: takes input beats, tracks the text cursor and queues draw/load commands.
// Depends on bgr_pkg.
module bgr_front import bgr_pkg::*; #(
  parameter int SCREEN_PIXELS_WIDE = DEF_SCREEN_PIXELS_WIDE,
  parameter int SCREEN_PIXELS_HIGH = DEF_SCREEN_PIXELS_HIGH,
  parameter int GLYPH_COUNT        = DEF_GLYPH_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // char_code[7:0], glyph_row[10:8], glyph_bits[18:11]
  input  logic [1:0]           s_axis_tuser,  // mode
  input  logic                 fifo_full,
  input  bgr_status_t          status,
  output logic                 push,
  output bgr_cmd_t             push_cmd
);

  localparam int COLS       = SCREEN_PIXELS_WIDE / CELL;
  localparam int LINES      = SCREEN_PIXELS_HIGH / CELL;
  localparam int LINE_BYTES = COLS * CELL;
  localparam int COL_W      = $clog2(COLS + 1);
  localparam int LINE_W     = $clog2(LINES);

  logic [COL_W-1:0]  column, column_next;
  logic [LINE_W-1:0] line, line_next;

  logic              accept;
  logic [7:0]        in_code;
  logic [2:0]        in_row;
  logic [7:0]        in_bits;
  logic              code_ok;
  logic              wrap;
  logic [LINE_W-1:0] line_inc;
  logic [COL_W-1:0]  eff_col;
  logic [LINE_W-1:0] eff_line;

  always_comb begin
    s_axis_tready = !fifo_full && !status.clearing;
    accept   = s_axis_tvalid && s_axis_tready;
    in_code  = s_axis_tdata[7:0];
    in_row   = s_axis_tdata[10:8];
    in_bits  = s_axis_tdata[18:11];
    code_ok  = {1'b0, in_code} < 9'(GLYPH_COUNT);
    line_inc = (line == LINE_W'(LINES - 1)) ? '0 : line + 1'b1;
    // column only rests at COLS after the last cell of a line
    wrap     = (column == COL_W'(COLS));
    eff_col  = wrap ? '0 : column;
    eff_line = wrap ? line_inc : line;

    column_next    = column;
    line_next      = line;
    push           = 1'b0;
    push_cmd.kind  = CMD_DRAW;
    push_cmd.code  = in_code;
    push_cmd.row   = in_row;
    push_cmd.bits  = in_bits;
    push_cmd.base  = ADDR_W'(LINE_BYTES * int'(eff_line)) + ADDR_W'(eff_col);
    push_cmd.blank = !code_ok;

    if (accept) begin
      unique case (mode_t'(s_axis_tuser))
        MODE_LOAD: begin
          push_cmd.kind = CMD_LOAD;
          push          = code_ok;
        end
        MODE_HOME: begin
          column_next = '0;
          line_next   = '0;
        end
        MODE_DRAW: begin
          if (in_code == NEWLINE_CODE) begin
            column_next = '0;
            line_next   = line_inc;
          end else begin
            push        = 1'b1;
            column_next = eff_col + 1'b1;
            line_next   = eff_line;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      line   <= '0;
    end else begin
      column <= column_next;
      line   <= line_next;
    end
  end

endmodule

// ===== rtl/bgr_cmd_fifo.sv =====
// Short command queue between the front end and the render back end.
// Depends on bgr_pkg for the command type.
module bgr_cmd_fifo import bgr_pkg::*; #(
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  bgr_cmd_t push_cmd,
  input  logic     pop,
  output bgr_cmd_t head,
  output logic     head_valid,
  output logic     full
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  bgr_cmd_t         slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  always_comb begin
    head_valid = (count != '0);
    full       = (count == CNT_W'(FIFO_DEPTH));
    head       = slots[rd_ptr];
    do_push    = push && !full;
    do_pop     = pop && head_valid;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// ===== rtl/bgr_back.sv =====
// Back end: owns the font memory, clears it after reset, applies row loads and
// streams eight framebuffer writes per drawn glyph. Depends on bgr_pkg.
module bgr_back import bgr_pkg::*; #(
  parameter int SCREEN_PIXELS_WIDE = DEF_SCREEN_PIXELS_WIDE,
  parameter int GLYPH_COUNT        = DEF_GLYPH_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bgr_cmd_t              head,
  input  logic                  head_valid,
  output logic                  pop,
  output bgr_status_t           status,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // fb_address[15:0], fb_data[23:16]
  output logic                  m_axis_tlast   // last_row
);

  localparam int COLS  = SCREEN_PIXELS_WIDE / CELL;
  localparam int DEPTH = GLYPH_COUNT * CELL;
  localparam int IDX_W = $clog2(DEPTH);

  logic [7:0] font_mem [DEPTH];

  back_state_t       state, state_next;
  logic [IDX_W-1:0]  clr_idx, clr_idx_next;
  logic [2:0]        row, row_next;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [7:0]        mem_wdata;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [7:0]        rd_data;

  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_last;
  logic              s1_blank;

  logic              out_valid;
  logic [ADDR_W-1:0] out_addr;
  logic [7:0]        out_data;
  logic              out_last;

  logic              out_free;
  logic              issue_ok;

  always_comb begin
    out_free = !out_valid || m_axis_tready;
    issue_ok = !s1_valid || out_free;

    state_next   = state;
    clr_idx_next = clr_idx;
    row_next     = row;
    pop          = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = clr_idx;
    mem_wdata    = '0;
    rd_en        = 1'b0;
    rd_addr      = {head.code[IDX_W-4:0], row};

    unique case (state)
      BK_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx == IDX_W'(DEPTH - 1)) begin
          state_next = BK_RUN;
        end else begin
          clr_idx_next = clr_idx + 1'b1;
        end
      end
      BK_RUN: begin
        if (head_valid) begin
          unique case (head.kind)
            CMD_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = {head.code[IDX_W-4:0], head.row};
              mem_wdata = head.bits;
              pop       = 1'b1;
            end
            CMD_DRAW: begin
              if (issue_ok) begin
                rd_en    = 1'b1;
                // out-of-range code: any entry will do, the row is blanked
                if (head.blank) begin
                  rd_addr = IDX_W'(row);
                end
                row_next = row + 1'b1;
                pop      = (row == 3'(CELL - 1));
              end
            end
          endcase
        end
      end
    endcase

    status.clearing = (state == BK_CLEAR);
    m_axis_tvalid   = out_valid;
    m_axis_tdata    = {out_data, out_addr};
    m_axis_tlast    = out_last;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= font_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_CLEAR;
      clr_idx <= '0;
      row     <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      row     <= row_next;
    end
  end

  // read stage, then output register; both advance only when downstream has room
  always_ff @(posedge clk) begin
    if (issue_ok) begin
      s1_addr  <= head.base + ADDR_W'(COLS * int'(row));
      s1_last  <= (row == 3'(CELL - 1));
      s1_blank <= head.blank;
    end
    if (out_free) begin
      out_addr <= s1_addr;
      out_data <= s1_blank ? 8'd0 : rd_data;
      out_last <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue_ok) begin
        s1_valid <= rd_en;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (rst)
    state == BK_CLEAR |-> !m_axis_tvalid && !s1_valid)
    else $error("output beat during font clear");

  a_draw_holds_head: assert property (@(posedge clk) disable iff (rst)
    row != 3'd0 |-> head_valid && head.kind == CMD_DRAW)
    else $error("draw command left queue head mid-glyph");

  a_draw_pops_on_last_row: assert property (@(posedge clk) disable iff (rst)
    pop && head.kind == CMD_DRAW |-> row == 3'(CELL - 1) && rd_en)
    else $error("draw popped before eighth row");

  a_single_port_use: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !rd_en)
    else $error("font memory written and read in one cycle");

endmodule

// ===== bench/tb_bitmap_text_glyph_renderer_core.sv =====
// Self-checking bench for bitmap_text_glyph_renderer_core: queued font loads, draws, homes
// and newlines go in as stream beats, and framebuffer writes are checked against a predictor.
// Depends on rtl/bgr_pkg.sv and rtl/bitmap_text_glyph_renderer_core.sv.
module tb_bitmap_text_glyph_renderer_core;
  import bgr_pkg::*;

  localparam int SCR_W       = DEF_SCREEN_PIXELS_WIDE;
  localparam int SCR_H       = DEF_SCREEN_PIXELS_HIGH;
  localparam int GLYPHS      = DEF_GLYPH_COUNT;
  localparam int COLS        = SCR_W / CELL;
  localparam int LINES       = SCR_H / CELL;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] code;
    logic [2:0] row;
    logic [7:0] bits;
  } glyph_op_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  data;
    logic        last;
  } fb_write_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // char_code, glyph_row, glyph_bits, zero pad
  logic [1:0]            s_axis_tuser = '0;  // mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // fb_address, fb_data
  logic                  m_axis_tlast;       // last_row

  glyph_op_t ops_to_send[$];
  fb_write_t fb_writes_due[$];
  glyph_op_t op_on_bus = '0;

  // predictor state
  logic [7:0] font_copy [0:GLYPHS*CELL-1];
  logic [6:0] cur_col  = '0;
  logic [5:0] cur_line = '0;

  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned sent = 0;
  int unsigned out_wait = 0;
  int unsigned out_beats = 0;
  int unsigned stall_left = 0;
  logic        long_stall_done = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  bitmap_text_glyph_renderer_core #(
    .SCREEN_PIXELS_WIDE(SCR_W),
    .SCREEN_PIXELS_HIGH(SCR_H),
    .GLYPH_COUNT(GLYPHS),
    .FIFO_DEPTH(DEF_FIFO_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void next_text_line();
    cur_col = '0;
    if (cur_line == LINES - 1) cur_line = '0;
    else cur_line = cur_line + 1'b1;
  endfunction

  // advance the cursor / font copy for one op and queue the writes it causes
  function automatic void render_op(input glyph_op_t op);
    fb_write_t w;
    int a;
    case (op.mode)
      MODE_LOAD: begin
        if (op.code < GLYPHS) font_copy[int'(op.code) * CELL + int'(op.row)] = op.bits;
      end
      MODE_HOME: begin
        cur_col  = '0;
        cur_line = '0;
      end
      MODE_DRAW: begin
        if (op.code == NEWLINE_CODE) begin
          next_text_line();
        end else begin
          if (cur_col >= COLS) next_text_line();
          for (int r = 0; r < CELL; r++) begin
            a = COLS * (int'(cur_line) * CELL + r) + int'(cur_col);
            w.addr = a[15:0];
            w.data = (op.code < GLYPHS) ? font_copy[int'(op.code) * CELL + r] : 8'd0;
            w.last = (r == CELL - 1);
            fb_writes_due.push_back(w);
          end
          cur_col = cur_col + 1'b1;
        end
      end
      default: ;  // unused mode is dropped
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    // half the picked draw codes come from a small pool, 32 to 47, the rest from the full code range
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(32, 47));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_op(input logic [1:0] m, input logic [7:0] c, input logic [2:0] r,
                         input logic [7:0] b);
    glyph_op_t op;
    op.mode = m;
    op.code = c;
    op.row  = r;
    op.bits = b;
    ops_to_send.push_back(op);
  endtask

  // sender: new beat only once the previous one went through and its gap is over
  always @(negedge clk) begin : drv
    glyph_op_t op;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (in_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (ops_to_send.size() != 0) begin
        op = ops_to_send.pop_front();
        s_axis_tdata  <= {5'd0, op.bits, op.row, op.code};
        s_axis_tuser  <= op.mode;
        op_on_bus     <= op;
        s_axis_tvalid <= 1'b1;
        in_gap <= ((sent % 50) >= 35) ? 0 : $urandom_range(0, 4);
        sent   <= sent + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: per-beat random wait, plus one long hold that backs the block up
  always @(negedge clk) begin : snk
    int unsigned w;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!long_stall_done && out_beats >= 40) begin
      long_stall_done <= 1'b1;
      stall_left <= 300;
      m_axis_tready <= 1'b0;
    end else begin
      if (out_taken) w = ((out_beats % 96) >= 64) ? 0 : $urandom_range(0, 4);
      else w = out_wait;
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        out_wait <= w - 1;
      end else begin
        m_axis_tready <= 1'b1;
        out_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin : mon
    fb_write_t exp;
    in_taken  <= !rst && s_axis_tvalid && s_axis_tready;
    out_taken <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) render_op(op_on_bus);
      if (m_axis_tvalid && m_axis_tready) begin
        out_beats <= out_beats + 1;
        if (fb_writes_due.size() == 0) begin
          $error("unexpected beat: fb_address %0d fb_data %02h",
                 m_axis_tdata[15:0], m_axis_tdata[23:16]);
          errors++;
        end else begin
          exp = fb_writes_due.pop_front();
          if (m_axis_tdata[15:0] !== exp.addr) begin
            $error("fb_address: expected %0d, got %0d", exp.addr, m_axis_tdata[15:0]);
            errors++;
          end
          if (m_axis_tdata[23:16] !== exp.data) begin
            $error("fb_data: expected %02h, got %02h", exp.data, m_axis_tdata[23:16]);
            errors++;
          end
          if (m_axis_tlast !== exp.last) begin
            $error("last_row: expected %0b, got %0b", exp.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main
    int n;
    logic [7:0] c;

    foreach (font_copy[i]) font_copy[i] = 8'd0;

    // directed: blank glyph after reset, row extremes, both newlines, unused mode, home
    push_op(MODE_DRAW, 8'd65, 3'd0, 8'h00);
    push_op(MODE_LOAD, 8'd255, 3'd0, 8'hFF);
    push_op(MODE_LOAD, 8'd255, 3'd7, 8'h80);
    push_op(MODE_LOAD, 8'd0, 3'd3, 8'h01);
    push_op(MODE_LOAD, NEWLINE_CODE, 3'd2, 8'h3C);
    push_op(MODE_DRAW, 8'd255, 3'd7, 8'hFF);
    push_op(MODE_DRAW, 8'd0, 3'd0, 8'h00);
    push_op(MODE_DRAW, NEWLINE_CODE, 3'd0, 8'h00);
    push_op(MODE_DRAW, NEWLINE_CODE, 3'd7, 8'hFF);
    push_op(MODE_UNUSED, 8'd255, 3'd7, 8'hFF);
    push_op(MODE_DRAW, 8'd255, 3'd0, 8'h00);
    push_op(MODE_HOME, 8'd0, 3'd0, 8'h00);
    push_op(MODE_DRAW, 8'd0, 3'd0, 8'h00);
    push_op(MODE_LOAD, 8'd170, 3'd5, 8'hAA);
    push_op(MODE_LOAD, 8'd85, 3'd2, 8'h55);
    push_op(MODE_DRAW, 8'd170, 3'd0, 8'h00);
    push_op(MODE_DRAW, 8'd85, 3'd0, 8'h00);
    push_op(MODE_HOME, 8'd255, 3'd7, 8'hFF);

    // fill a whole text line so the cursor rests at the right edge and wraps,
    // then enough newlines to run off the bottom, then draw again near the top
    n = COLS + 1 + $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: c = 8'd170;
        1: c = 8'd85;
        2: c = 8'd255;
        default: begin
          c = pick_code();
          if (c == NEWLINE_CODE) c = 8'd11;
        end
      endcase
      push_op(MODE_DRAW, c, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end
    n = LINES - 1 + $urandom_range(0, 2);
    for (int i = 0; i < n; i++) push_op(MODE_DRAW, NEWLINE_CODE, 3'd0, 8'h00);
    for (int i = 0; i < 3; i++) begin
      c = pick_code();
      if (c == NEWLINE_CODE) c = 8'd12;
      push_op(MODE_DRAW, c, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end

    @(negedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (ops_to_send.size() != 0 || s_axis_tvalid || fb_writes_due.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== bitmap_text_glyph_renderer_core.f =====
rtl/bgr_pkg.sv
rtl/bgr_front.sv
rtl/bgr_cmd_fifo.sv
rtl/bgr_back.sv
rtl/bitmap_text_glyph_renderer_core.sv
bench/tb_bitmap_text_glyph_renderer_core.sv
